// ===== design/tmce_pkg.sv =====
package tmce_pkg;

  localparam int unsigned SCREEN_COLUMNS_DEF = 80;
  localparam int unsigned SCREEN_ROWS_DEF    = 25;

  localparam logic [7:0] TTY_ATTR   = 8'h07;
  localparam logic [7:0] RESET_MODE = 8'h03;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CTL_CR     = 8'h0D;
  localparam logic [7:0] CTL_LF     = 8'h0A;
  localparam logic [7:0] CTL_BS     = 8'h08;
  localparam logic [7:0] LAST_CLEARING_MODE = 8'h03;

  typedef enum logic [3:0] {
    ACT_SET_MODE   = 4'd0,
    ACT_SET_CURSOR = 4'd1,
    ACT_GET_CURSOR = 4'd2,
    ACT_CLEAR_FILL = 4'd3,
    ACT_READ_CELL  = 4'd4,
    ACT_WRITE_CA   = 4'd5,
    ACT_WRITE_CHAR = 4'd6,
    ACT_TELETYPE   = 4'd7,
    ACT_GET_MODE   = 4'd8,
    ACT_NOP        = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RUN
  } state_e;

endpackage

// ===== design/text_mode_console_engine_unit.sv =====
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-----------------------------------
// request  | action_i .. repeat_count_i              | taken when start_i & !busy_o
// result   | cursor_row_o .. echo_char_o             | valid for one cycle while done_o
//
// Most requests need no sweep: the result strobe follows the accepting edge.
// Clear fill with zero lines and set mode to modes 0..3 sweep the cell memory, one cell
// per cycle. Write requests with a nonzero count and the cursor on screen walk their
// run one cell per cycle (read and write pipelined), the run stopping at the last
// cell of the screen. After reset the memory is zeroed by a sweep with busy_o high.
// The receiver cannot stall results.
module text_mode_console_engine_unit #(
  parameter int unsigned SCREEN_COLUMNS = tmce_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = tmce_pkg::SCREEN_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  action_i,
  input  logic [7:0]  new_mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  attr_byte_i,
  input  logic [7:0]  scroll_lines_i,
  input  logic [7:0]  row_in_i,
  input  logic [7:0]  col_in_i,
  input  logic [15:0] repeat_count_i,
  output logic        done_o,
  output logic [7:0]  cursor_row_o,
  output logic [7:0]  cursor_col_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  output logic [7:0]  mode_out_o,
  output logic        echo_valid_o,
  output logic [7:0]  echo_char_o
);
  import tmce_pkg::*;

  localparam int unsigned CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [8:0] ROWS_9 = 9'(SCREEN_ROWS);
  localparam logic [8:0] COLS_9 = 9'(SCREEN_COLUMNS);
  localparam logic [7:0] LAST_ROW = 8'(SCREEN_ROWS - 1);

  logic [15:0] mem [CELL_COUNT];

  state_e state_q, state_d;
  logic [7:0] cur_row_q, cur_row_d, cur_col_q, cur_col_d, mode_q, mode_d;
  logic [ADDR_W-1:0] clr_idx_q, clr_idx_d;
  logic [15:0] fill_q, fill_d;
  logic clr_report_q, clr_report_d;
  logic [ADDR_W-1:0] run_idx_q, run_idx_d, pend_idx_q, pend_idx_d;
  logic [15:0] run_left_q, run_left_d;
  logic pend_q, pend_d, keep_attr_q, keep_attr_d;
  logic [7:0] run_char_q, run_char_d, run_attr_q, run_attr_d;
  logic done_q, done_d, show_rd_q, show_rd_d, echo_valid_q, echo_valid_d;
  logic [7:0] echo_char_q, echo_char_d;
  logic [15:0] rd_q;

  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  logic accept, on_screen, run_issue, run_start, clr_start;
  logic [ADDR_W-1:0] cur_idx;
  logic [8:0] row_inc, col_inc;
  logic [7:0] row_next_line;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign on_screen = (cur_row_q < 8'(SCREEN_ROWS)) && (cur_col_q < 8'(SCREEN_COLUMNS));
  assign cur_idx = ADDR_W'(ADDR_W'(cur_row_q) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(cur_col_q));
  assign row_inc = {1'b0, cur_row_q} + 9'd1;
  assign col_inc = {1'b0, cur_col_q} + 9'd1;
  assign row_next_line = (row_inc >= ROWS_9) ? LAST_ROW : row_inc[7:0];
  assign run_issue = (state_q == ST_RUN) && (run_left_q != '0);

  assign run_start = (action_i inside {ACT_WRITE_CA, ACT_WRITE_CHAR})
                     && on_screen && (repeat_count_i != '0);
  assign clr_start = ((action_i == ACT_SET_MODE) && (new_mode_i <= LAST_CLEARING_MODE))
                     || ((action_i == ACT_CLEAR_FILL) && (scroll_lines_i == '0));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && clr_start) begin
          state_d = ST_CLEAR;
        end else if (accept && run_start) begin
          state_d = ST_RUN;
        end
      end
      ST_CLEAR: begin
        if (clr_idx_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        if ((run_left_q == '0) && !pend_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    mode_d       = mode_q;
    clr_idx_d    = clr_idx_q;
    fill_d       = fill_q;
    clr_report_d = clr_report_q;
    run_idx_d    = run_idx_q;
    run_left_d   = run_left_q;
    pend_d       = 1'b0;
    pend_idx_d   = run_idx_q;
    keep_attr_d  = keep_attr_q;
    run_char_d   = run_char_q;
    run_attr_d   = run_attr_q;
    done_d       = 1'b0;
    show_rd_d    = show_rd_q;
    echo_valid_d = echo_valid_q;
    echo_char_d  = echo_char_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_idx;
    mem_wdata    = {TTY_ATTR, char_code_i};
    mem_re       = 1'b0;
    mem_raddr    = cur_idx;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          show_rd_d    = 1'b0;
          echo_valid_d = 1'b0;
          echo_char_d  = '0;
          done_d       = !(clr_start || run_start);
          clr_idx_d    = '0;
          clr_report_d = 1'b1;
          run_idx_d    = cur_idx;
          run_left_d   = repeat_count_i;
          keep_attr_d  = (action_i == ACT_WRITE_CHAR);
          run_char_d   = char_code_i;
          run_attr_d   = attr_byte_i;
          case (action_i)
            ACT_SET_MODE: begin
              mode_d    = new_mode_i;
              cur_row_d = '0;
              cur_col_d = '0;
              fill_d    = '0;
            end
            ACT_SET_CURSOR: begin
              cur_row_d = row_in_i;
              cur_col_d = col_in_i;
            end
            ACT_CLEAR_FILL: begin
              fill_d = {attr_byte_i, SPACE_CHAR};
            end
            ACT_READ_CELL: begin
              mem_re    = on_screen;
              show_rd_d = on_screen;
            end
            ACT_TELETYPE: begin
              if (char_code_i == CTL_CR) begin
                cur_col_d = '0;
              end else if (char_code_i == CTL_LF) begin
                cur_row_d = row_next_line;
              end else if (char_code_i == CTL_BS) begin
                if (cur_col_q != '0) begin
                  cur_col_d = cur_col_q - 8'd1;
                end
              end else if ((char_code_i >= SPACE_CHAR) && on_screen) begin
                mem_we       = 1'b1;
                echo_valid_d = 1'b1;
                echo_char_d  = char_code_i;
                if (col_inc >= COLS_9) begin
                  cur_col_d = '0;
                  cur_row_d = row_next_line;
                end else begin
                  cur_col_d = col_inc[7:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = fill_q;
        clr_idx_d = clr_idx_q + ADDR_W'(1);
        if (clr_idx_q == LAST_CELL) begin
          done_d = clr_report_q;
        end
      end
      ST_RUN: begin
        // Each cycle reads the next cell and writes back the one read before.
        mem_re    = run_issue;
        mem_raddr = run_idx_q;
        if (run_issue) begin
          pend_d     = 1'b1;
          run_idx_d  = run_idx_q + ADDR_W'(1);
          run_left_d = (run_idx_q == LAST_CELL) ? '0 : run_left_q - 16'd1;
        end
        mem_we    = pend_q;
        mem_waddr = pend_idx_q;
        mem_wdata = keep_attr_q ? {rd_q[15:8], run_char_q} : {run_attr_q, run_char_q};
        if ((run_left_q == '0) && !pend_q) begin
          done_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      mode_q       <= RESET_MODE;
      clr_idx_q    <= '0;
      fill_q       <= '0;
      clr_report_q <= 1'b0;
      run_left_q   <= '0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      show_rd_q    <= 1'b0;
      echo_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      mode_q       <= mode_d;
      clr_idx_q    <= clr_idx_d;
      fill_q       <= fill_d;
      clr_report_q <= clr_report_d;
      run_left_q   <= run_left_d;
      pend_q       <= pend_d;
      done_q       <= done_d;
      show_rd_q    <= show_rd_d;
      echo_valid_q <= echo_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_idx_q   <= run_idx_d;
    pend_idx_q  <= pend_idx_d;
    keep_attr_q <= keep_attr_d;
    run_char_q  <= run_char_d;
    run_attr_q  <= run_attr_d;
    echo_char_q <= echo_char_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign cursor_row_o = cur_row_q;
  assign cursor_col_o = cur_col_q;
  assign cell_char_o  = show_rd_q ? rd_q[7:0] : 8'h00;
  assign cell_attr_o  = show_rd_q ? rd_q[15:8] : 8'h00;
  assign mode_out_o   = mode_q;
  assign echo_valid_o = echo_valid_q;
  assign echo_char_o  = echo_valid_q ? echo_char_q : 8'h00;

endmodule

// ===== verif/tb_text_mode_console_engine_unit.sv =====
module tb_text_mode_console_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tmce_pkg::*;

  localparam int unsigned COLS        = SCREEN_COLUMNS_DEF;
  localparam int unsigned ROWS        = SCREEN_ROWS_DEF;
  localparam int unsigned CELLS       = COLS * ROWS;
  localparam int unsigned CELL_W      = $clog2(CELLS);
  localparam int unsigned LOG_DEPTH   = 16;
  localparam int unsigned LOG_W       = $clog2(LOG_DEPTH);
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned RANDOM_REQS = 372;
  localparam logic [3:0]  ACT_UNKNOWN_TOP = 4'hF;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  new_mode;
    logic [7:0]  char_code;
    logic [7:0]  attr_byte;
    logic [7:0]  scroll_lines;
    logic [7:0]  row_in;
    logic [7:0]  col_in;
    logic [15:0] repeat_count;
    logic        drain_first;
  } console_req_t;

  typedef struct packed {
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [7:0] mode_out;
    logic       echo_valid;
    logic [7:0] echo_char;
  } console_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [3:0]  action_i = '0;
  logic [7:0]  new_mode_i = '0;
  logic [7:0]  char_code_i = '0;
  logic [7:0]  attr_byte_i = '0;
  logic [7:0]  scroll_lines_i = '0;
  logic [7:0]  row_in_i = '0;
  logic [7:0]  col_in_i = '0;
  logic [15:0] repeat_count_i = '0;
  logic        done_o;
  logic [7:0]  cursor_row_o;
  logic [7:0]  cursor_col_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attr_o;
  logic [7:0]  mode_out_o;
  logic        echo_valid_o;
  logic [7:0]  echo_char_o;

  // Mirror of the screen, cursor and mode as the block should hold them.
  logic [15:0] screen_mirror [CELLS];
  logic [7:0]  mirror_row;
  logic [7:0]  mirror_col;
  logic [7:0]  mirror_mode;
  logic [7:0]  mirror_tty_attr;

  console_req_t    request_backlog [$];
  console_req_t    active_req;
  console_status_t awaited_status [LOG_DEPTH];
  int unsigned     req_taken = 0;
  int unsigned     status_seen = 0;
  int unsigned     fault_count = 0;
  int unsigned     gap_left = 0;
  int unsigned     calm_left = 0;
  int unsigned     stall_cycles = 0;

  text_mode_console_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .new_mode_i     (new_mode_i),
    .char_code_i    (char_code_i),
    .attr_byte_i    (attr_byte_i),
    .scroll_lines_i (scroll_lines_i),
    .row_in_i       (row_in_i),
    .col_in_i       (col_in_i),
    .repeat_count_i (repeat_count_i),
    .done_o         (done_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_col_o   (cursor_col_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o),
    .mode_out_o     (mode_out_o),
    .echo_valid_o   (echo_valid_o),
    .echo_char_o    (echo_char_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void advance_line();
    if (mirror_row >= 8'(ROWS - 1)) begin
      mirror_row = 8'(ROWS - 1);
    end else begin
      mirror_row = mirror_row + 8'd1;
    end
  endfunction

  function automatic console_status_t service_request(input console_req_t rq);
    console_status_t   st;
    logic              on_screen;
    logic [CELL_W-1:0] idx;
    logic [15:0]       left;
    st = '0;
    on_screen = (mirror_row < 8'(ROWS)) && (mirror_col < 8'(COLS));
    idx = CELL_W'(mirror_row * COLS + mirror_col);
    case (rq.action)
      ACT_SET_MODE: begin
        mirror_mode = rq.new_mode;
        mirror_row = '0;
        mirror_col = '0;
        mirror_tty_attr = TTY_ATTR;
        if (rq.new_mode <= LAST_CLEARING_MODE) begin
          foreach (screen_mirror[i]) screen_mirror[i] = '0;
        end
      end
      ACT_SET_CURSOR: begin
        mirror_row = rq.row_in;
        mirror_col = rq.col_in;
      end
      ACT_CLEAR_FILL: begin
        if (rq.scroll_lines == 8'd0) begin
          foreach (screen_mirror[i]) screen_mirror[i] = {rq.attr_byte, SPACE_CHAR};
        end
      end
      ACT_READ_CELL: begin
        if (on_screen) begin
          {st.cell_attr, st.cell_char} = screen_mirror[idx];
        end
      end
      ACT_WRITE_CA, ACT_WRITE_CHAR: begin
        if (on_screen) begin
          left = rq.repeat_count;
          // The run crosses row ends but never goes past the last cell.
          while (left != '0 && idx < CELL_W'(CELLS)) begin
            if (rq.action == ACT_WRITE_CA) begin
              screen_mirror[idx] = {rq.attr_byte, rq.char_code};
            end else begin
              screen_mirror[idx][7:0] = rq.char_code;
            end
            idx++;
            left--;
          end
        end
      end
      ACT_TELETYPE: begin
        if (rq.char_code == CTL_CR) begin
          mirror_col = '0;
        end else if (rq.char_code == CTL_LF) begin
          advance_line();
        end else if (rq.char_code == CTL_BS) begin
          if (mirror_col != 8'd0) mirror_col = mirror_col - 8'd1;
        end else if (rq.char_code >= SPACE_CHAR && on_screen) begin
          screen_mirror[idx] = {mirror_tty_attr, rq.char_code};
          if (mirror_col == 8'(COLS - 1)) begin
            mirror_col = '0;
            advance_line();
          end else begin
            mirror_col = mirror_col + 8'd1;
          end
          st.echo_valid = 1'b1;
          st.echo_char = rq.char_code;
        end
      end
      default: begin
      end
    endcase
    st.cursor_row = mirror_row;
    st.cursor_col = mirror_col;
    st.mode_out = mirror_mode;
    return st;
  endfunction

  // Fields that the action ignores still carry random values.
  function automatic console_req_t scrambled_request(input logic [3:0] act);
    console_req_t rq;
    rq.action = act;
    rq.new_mode = 8'($urandom);
    rq.char_code = 8'($urandom);
    rq.attr_byte = 8'($urandom);
    rq.scroll_lines = 8'($urandom);
    rq.row_in = 8'($urandom);
    rq.col_in = 8'($urandom);
    rq.repeat_count = 16'($urandom);
    rq.drain_first = 1'b0;
    return rq;
  endfunction

  function automatic console_req_t random_request();
    console_req_t rq;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < 14) begin
      rq = scrambled_request(ACT_SET_CURSOR);
      if ($urandom_range(4) != 0) begin
        rq.row_in = ($urandom_range(3) == 0) ? 8'(ROWS - 1) : 8'($urandom_range(ROWS - 1));
        case ($urandom_range(3))
          0:       rq.col_in = 8'(COLS - 1);
          1:       rq.col_in = 8'(COLS - 2);
          default: rq.col_in = 8'($urandom_range(COLS - 1));
        endcase
      end
    end else if (pick < 28) begin
      rq = scrambled_request(ACT_READ_CELL);
    end else if (pick < 48) begin
      rq = scrambled_request(ACT_TELETYPE);
      case ($urandom_range(7))
        0:       rq.char_code = CTL_CR;
        1:       rq.char_code = CTL_LF;
        2:       rq.char_code = CTL_BS;
        3:       rq.char_code = 8'($urandom_range(31));
        default: rq.char_code = 8'($urandom_range(255, 32));
      endcase
    end else if (pick < 68) begin
      rq = scrambled_request((pick < 58) ? ACT_WRITE_CA : ACT_WRITE_CHAR);
      pick = $urandom_range(99);
      // Long runs walk the memory a cell per cycle, so only a few are long.
      if (pick < 85) begin
        rq.repeat_count = 16'($urandom_range(120));
      end else if (pick < 97) begin
        rq.repeat_count = 16'($urandom_range(CELLS, 121));
      end
    end else if (pick < 73) begin
      rq = scrambled_request(ACT_GET_CURSOR);
    end else if (pick < 77) begin
      rq = scrambled_request(ACT_GET_MODE);
    end else if (pick < 80) begin
      rq = scrambled_request(ACT_NOP);
    end else if (pick < 84) begin
      rq = scrambled_request(4'($urandom_range(ACT_UNKNOWN_TOP, int'(ACT_NOP) + 1)));
    end else if (pick < 92) begin
      rq = scrambled_request(ACT_SET_MODE);
      if ($urandom_range(3) == 0) rq.new_mode = 8'($urandom_range(LAST_CLEARING_MODE));
    end else begin
      rq = scrambled_request(ACT_CLEAR_FILL);
      rq.scroll_lines = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 1));
    end
    rq.drain_first = ($urandom_range(99) < 3);
    return rq;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm_left = $urandom_range(40, 20);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Request driver: predicts at the accepting edge, then presents the next request.
  always @(posedge clk_i or negedge rst_ni) begin
    logic        took;
    int unsigned taken_total;
    if (!rst_ni) begin
      start_i <= 1'b0;
      action_i <= '0;
      new_mode_i <= '0;
      char_code_i <= '0;
      attr_byte_i <= '0;
      scroll_lines_i <= '0;
      row_in_i <= '0;
      col_in_i <= '0;
      repeat_count_i <= '0;
      req_taken <= 0;
      gap_left = 0;
      foreach (screen_mirror[i]) screen_mirror[i] = '0;
      mirror_row = '0;
      mirror_col = '0;
      mirror_mode = RESET_MODE;
      mirror_tty_attr = TTY_ATTR;
    end else begin
      took = start_i && !busy_o;
      taken_total = req_taken + (took ? 1 : 0);
      if (took) begin
        awaited_status[LOG_W'(req_taken % LOG_DEPTH)] <= service_request(active_req);
        req_taken <= taken_total;
      end
      if (!start_i || !busy_o) begin
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain_first && taken_total != status_seen)) begin
          active_req = request_backlog.pop_front();
          action_i <= active_req.action;
          new_mode_i <= active_req.new_mode;
          char_code_i <= active_req.char_code;
          attr_byte_i <= active_req.attr_byte;
          scroll_lines_i <= active_req.scroll_lines;
          row_in_i <= active_req.row_in;
          col_in_i <= active_req.col_in;
          repeat_count_i <= active_req.repeat_count;
          start_i <= 1'b1;
          gap_left = idle_gap();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    console_status_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (status_seen == req_taken) begin
        fault_count++;
        $display("%0t: result mismatch, expected none, actual row %0h col %0h", $time,
                 cursor_row_o, cursor_col_o);
      end else begin
        want = awaited_status[LOG_W'(status_seen % LOG_DEPTH)];
        compare_field("cursor_row", want.cursor_row, cursor_row_o);
        compare_field("cursor_col", want.cursor_col, cursor_col_o);
        compare_field("cell_char", want.cell_char, cell_char_o);
        compare_field("cell_attr", want.cell_attr, cell_attr_o);
        compare_field("mode_out", want.mode_out, mode_out_o);
        compare_field("echo_valid", 8'(want.echo_valid), 8'(echo_valid_o));
        compare_field("echo_char", want.echo_char, echo_char_o);
        status_seen <= status_seen + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    console_req_t rq;

    rq = scrambled_request(ACT_GET_MODE);
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = 8'h41;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_SET_CURSOR);
    rq.row_in = 8'd0;
    rq.col_in = 8'd0;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_READ_CELL);
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_CLEAR_FILL);
    rq.scroll_lines = 8'd0;
    rq.attr_byte = 8'hFF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_CLEAR_FILL);
    rq.scroll_lines = 8'hFF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_READ_CELL);
    request_backlog.push_back(rq);
    // Runs that start near the last cell must stop there.
    rq = scrambled_request(ACT_SET_CURSOR);
    rq.row_in = 8'(ROWS - 1);
    rq.col_in = 8'(COLS - 2);
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_WRITE_CA);
    rq.char_code = 8'h00;
    rq.attr_byte = 8'h00;
    rq.repeat_count = 16'hFFFF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_WRITE_CHAR);
    rq.char_code = 8'hFF;
    rq.repeat_count = 16'd3;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_WRITE_CHAR);
    rq.repeat_count = 16'd0;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_READ_CELL);
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = 8'hFF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = SPACE_CHAR;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = CTL_LF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = CTL_BS;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = 8'h01;
    request_backlog.push_back(rq);
    // Off-screen cursor: reads give zero, writes and printing are dropped.
    rq = scrambled_request(ACT_SET_CURSOR);
    rq.row_in = 8'hFF;
    rq.col_in = 8'hFF;
    rq.drain_first = 1'b1;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_READ_CELL);
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_WRITE_CA);
    rq.repeat_count = 16'd10;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = 8'h7E;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = CTL_BS;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = CTL_LF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_TELETYPE);
    rq.char_code = CTL_CR;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_SET_MODE);
    rq.new_mode = 8'hFF;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_SET_MODE);
    rq.new_mode = 8'h00;
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_NOP);
    request_backlog.push_back(rq);
    rq = scrambled_request(ACT_UNKNOWN_TOP);
    request_backlog.push_back(rq);

    repeat (RANDOM_REQS) request_backlog.push_back(random_request());

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_backlog.size() != 0 || start_i || req_taken != status_seen) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
